// ===== rtl/set_assoc_cache_lru_counters_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag and LRU engine
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_COUNTERS_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_COUNTERS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sac_pkg.sv =====
// ---------------------------------------------------------------------------
// sac_pkg
// Sizes, types and the set row layout of the cache tag and LRU engine.
// ---------------------------------------------------------------------------
package sac_pkg;

    localparam int SETS        = 128;
    localparam int WAYS        = 8;
    localparam int TAG_BITS    = 19;
    localparam int INDEX_SHIFT = 6;
    localparam int COUNT_BITS  = 3;
    localparam int ADDR_BITS   = 32;

    localparam int IDX_BITS = $clog2(SETS);
    localparam int WAY_BITS = $clog2(WAYS);

    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [WAY_BITS-1:0]   t_way;
    typedef logic [COUNT_BITS-1:0] t_age;

    localparam t_age COUNT_MAX = '1;

    // One memory row holds the whole set: valid bits, tags and age counters.
    typedef struct packed {
        logic [WAYS-1:0]                vld;
        logic [WAYS-1:0][TAG_BITS-1:0]  tags;
        logic [WAYS-1:0][COUNT_BITS-1:0] ages;
    } t_row;

endpackage

// ===== rtl/sac_in_if.sv =====
// ---------------------------------------------------------------------------
// sac_in_if
// Request channel: one read address per beat.
// ---------------------------------------------------------------------------
interface sac_in_if;
    import sac_pkg::*;

    logic  valid;
    logic  ready;
    t_addr address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);

endinterface

// ===== rtl/sac_out_if.sv =====
// ---------------------------------------------------------------------------
// sac_out_if
// Result channel: hit flag and the way that was hit or refilled per beat.
// ---------------------------------------------------------------------------
interface sac_out_if;
    import sac_pkg::*;

    logic valid;
    logic ready;
    logic hit;
    t_way way;

    modport source (output valid, output hit, output way, input ready);
    modport sink   (input valid, input hit, input way, output ready);

endinterface

// ===== rtl/set_assoc_cache_lru_counters_unit.sv =====
// An accepted request passes the lookup stage registers, then the output register.
// A new request waits until the lookup completes (which needs a free output register);
// the set row in the single set memory is read on accept, written back on completion.
// Reset clears the per-set row-valid flops at once; there is no clearing pass,
// and a set whose row was never written reads as all ways invalid, ages zero.
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_counters_unit
// Tag lookup and counter-based LRU replacement for an 8-way, 128-set cache.
// ---------------------------------------------------------------------------
`include "set_assoc_cache_lru_counters_unit_defines.svh"

module set_assoc_cache_lru_counters_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sac_in_if.sink    i_in,
    sac_out_if.source o_out
);
    import sac_pkg::*;

    // Set memory and per-set row-valid flags.
    t_row            r_set_mem [SETS];
    logic [SETS-1:0] r_row_vld;

    // Lookup stage registers.
    logic r_busy;
    t_idx r_idx;
    t_tag r_tag;
    logic r_row_live;
    t_row r_rd_row;

    // Output register.
    logic r_out_valid;
    logic r_hit;
    t_way r_way;

    logic w_in_fire;
    logic w_fire;
    t_idx w_in_idx;
    t_tag w_in_tag;

    logic [WAYS-1:0]                 w_vld_eff;
    logic [WAYS-1:0][COUNT_BITS-1:0] w_ages_eff;
    logic w_hit;
    t_way w_hit_way;
    t_way w_victim;
    t_way w_sel;
    t_row n_row;

    // Address split into set index and tag.
    assign w_in_idx = i_in.address[INDEX_SHIFT +: IDX_BITS];
    assign w_in_tag = i_in.address[INDEX_SHIFT + IDX_BITS +: TAG_BITS];

    // A new beat is taken whenever no lookup is in flight.
    assign i_in.ready = !r_busy;
    assign w_in_fire  = i_in.valid && !r_busy;

    // The lookup completes once the output register is free or being drained.
    assign w_fire = r_busy && (!r_out_valid || o_out.ready);

    // A never-written set reads as its reset contents.
    assign w_vld_eff  = r_row_live ? r_rd_row.vld  : '0;
    assign w_ages_eff = r_row_live ? r_rd_row.ages : '0;

    // Tag compare, victim pick and counter update for the set being worked on.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_way = '0;
        // Descending scan so that the lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_vld_eff[w] && (r_rd_row.tags[w] == r_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_BITS'(w);
            end
        end

        // Highest-numbered way with a zero counter, way 0 if there is none.
        w_victim = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_ages_eff[w] == '0) begin
                w_victim = WAY_BITS'(w);
            end
        end

        w_sel = w_hit ? w_hit_way : w_victim;

        n_row      = r_rd_row;
        n_row.vld  = w_vld_eff;
        n_row.ages = w_ages_eff;
        if (!w_hit) begin
            n_row.tags[w_sel] = r_tag;
            n_row.vld[w_sel]  = 1'b1;
        end
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_BITS'(w) == w_sel) begin
                n_row.ages[w] = COUNT_MAX;
            end else if (w_ages_eff[w] != '0) begin
                n_row.ages[w] = w_ages_eff[w] - 1'b1;
            end
        end
    end

    // Set memory: row read on accept, row written back when the lookup completes.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rd_row <= r_set_mem[w_in_idx];
        end
        if (w_fire) begin
            r_set_mem[r_idx] <= n_row;
        end
    end

    // Lookup stage payload.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_idx <= w_in_idx;
            r_tag <= w_in_tag;
        end
        if (w_fire) begin
            r_hit <= w_hit;
            r_way <= w_sel;
        end
    end

    // Control state and row-valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_vld   <= '0;
            r_row_live  <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_busy     <= 1'b1;
                r_row_live <= r_row_vld[w_in_idx];
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end

            if (w_fire) begin
                r_row_vld[r_idx] <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.hit   = r_hit;
    assign o_out.way   = r_way;

    // Checks on the lookup pipeline.
    `SAC_ASSERT_NEXT(a_accept_busy, w_in_fire, r_busy, "accepted beat did not start a lookup")
    `SAC_ASSERT_NEXT(a_fire_result, w_fire, o_out.valid && !r_busy, "lookup did not yield a result")
    `SAC_ASSERT_SAME(a_hit_is_valid, w_fire && w_hit, w_vld_eff[w_hit_way], "hit on an invalid way")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the 8-way tag lookup and counter LRU engine against its own model of
// the set contents, one expected hit/way pair per accepted address beat.
// ---------------------------------------------------------------------------
module testbench;
    import sac_pkg::*;

    // Address beat waiting to be offered; drain asks for an empty pipe first.
    typedef struct {
        t_addr addr;
        bit    drain;
    } t_req;

    // Expected outcome of one lookup.
    typedef struct {
        t_addr address;
        logic  hit;
        t_way  way;
    } t_lookup;

    typedef enum {SEG_WORKING, SEG_HAMMER, SEG_NOISE} t_seg_kind;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall_kind;

    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sac_in_if  in_if ();
    sac_out_if out_if ();

    set_assoc_cache_lru_counters_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    // Model of the set memory; valid bits and counters start cleared.
    bit   model_valid [SETS][WAYS];
    t_tag model_tag   [SETS][WAYS];
    t_age model_age   [SETS][WAYS] = '{default: '0};

    t_req    pending_q[$];
    t_lookup lookups_due[$];
    int      results_open = 0;
    int      errors       = 0;
    int      checked      = 0;
    int      hits_seen    = 0;
    int      fills        = 0;
    int      evictions    = 0;
    bit      long_hold_done = 1'b0;

    // Look up one address in the model, refill on a miss and age the set.
    function automatic t_lookup cache_lookup(t_addr addr);
        t_idx    set_idx;
        t_tag    tag;
        t_way    chosen;
        logic    hit;
        t_lookup res;
        set_idx = addr[INDEX_SHIFT +: IDX_BITS];
        tag     = addr[INDEX_SHIFT + IDX_BITS +: TAG_BITS];
        chosen  = '0;
        hit     = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && model_valid[set_idx][w] && model_tag[set_idx][w] == tag) begin
                hit    = 1'b1;
                chosen = t_way'(w);
            end
        end
        // Miss: the highest-numbered way with a zero counter, way 0 if none.
        if (!hit) begin
            for (int w = 0; w < WAYS; w++) begin
                if (model_age[set_idx][w] == '0) chosen = t_way'(w);
            end
            if (model_valid[set_idx][chosen]) evictions++;
            model_tag[set_idx][chosen]   = tag;
            model_valid[set_idx][chosen] = 1'b1;
            fills++;
        end else begin
            hits_seen++;
        end
        // The touched way becomes youngest; other live counters count down.
        for (int w = 0; w < WAYS; w++) begin
            if (w == chosen) model_age[set_idx][w] = COUNT_MAX;
            else if (model_age[set_idx][w] != '0) model_age[set_idx][w] -= 1'b1;
        end
        res.address = addr;
        res.hit     = hit;
        res.way     = chosen;
        return res;
    endfunction

    function automatic t_addr make_addr(t_tag tag, t_idx idx, logic [INDEX_SHIFT-1:0] off);
        return {tag, idx, off};
    endfunction

    task automatic add_req(t_addr addr, bit drain);
        t_req r;
        r.addr  = addr;
        r.drain = drain;
        pending_q.push_back(r);
    endtask

    // Driver: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_req nxt;
        bit   offer;
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.address <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                // A drain beat waits until every outstanding result is back.
                if (!pending_q[0].drain || (!in_if.valid && results_open == 0)) begin
                    nxt   = pending_q.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_if.valid <= offer;
            if (offer) in_if.address <= nxt.addr;
        end
    end

    // Monitor: predict on every accepted address, check every accepted result.
    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) lookups_due.push_back(cache_lookup(in_if.address));
            if (out_if.valid && out_if.ready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t: unexpected result beat: hit %0d way %0d",
                             $time, out_if.hit, out_if.way);
                    errors++;
                end else begin
                    exp_r = lookups_due.pop_front();
                    checked++;
                    if (out_if.hit !== exp_r.hit) begin
                        $display("%0t: hit mismatch for address %h: expected %0d, actual %0d",
                                 $time, exp_r.address, exp_r.hit, out_if.hit);
                        errors++;
                    end
                    if (out_if.way !== exp_r.way) begin
                        $display("%0t: way mismatch for address %h: expected %0d, actual %0d",
                                 $time, exp_r.address, exp_r.way, out_if.way);
                        errors++;
                    end
                end
            end
            results_open <= lookups_due.size();
        end
    end

    // Receiver: stall patterns that change over time, plus one long hold-off.
    int          taken       = 0;
    int          hold_left   = 0;
    int          pattern_left = 0;
    int          phase       = 0;
    t_stall_kind stall_mode  = STALL_NONE;

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) taken++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_hold_done && taken >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                rdy            = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    stall_mode   = t_stall_kind'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                phase++;
                case (stall_mode)
                    STALL_NONE:     rdy = 1'b1;
                    STALL_LIGHT:    rdy = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: rdy = ((phase % 3) != 0);
                    default:        rdy = 1'($urandom_range(0, 1));
                endcase
            end
            out_if.ready <= rdy;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_idx      seg_sets[4];
        t_tag      seg_tags[12];
        int        n_sets;
        int        n_tags;
        int        seg_len;
        int        total;
        bit        drained;
        t_seg_kind kind;
        t_addr     addr;

        in_if.valid   = 1'b0;
        in_if.address = '0;
        out_if.ready  = 1'b0;

        // Address extremes and the boundary constants.
        add_req(32'h0000_0000, 1'b0);
        add_req(32'hFFFF_FFFF, 1'b0);
        add_req(32'h0000_003F, 1'b0);
        add_req(32'h47FF_FFFF, 1'b0);
        add_req(32'hFFF8_0000, 1'b0);
        add_req(32'h8000_0000, 1'b0);
        add_req(32'hFFFF_FFC0, 1'b0);
        // Fill one set, hit in it, then force replacement of the oldest way.
        for (int t = 1; t <= WAYS; t++) begin
            add_req(make_addr(t_tag'(t), t_idx'(42), INDEX_SHIFT'(t)), 1'b0);
        end
        add_req(make_addr(t_tag'(3), t_idx'(42), INDEX_SHIFT'(0)), 1'b0);
        add_req(make_addr(t_tag'(9), t_idx'(42), INDEX_SHIFT'(0)), 1'b0);
        add_req(make_addr(t_tag'(1), t_idx'(42), INDEX_SHIFT'(0)), 1'b0);
        add_req(make_addr(t_tag'(9), t_idx'(42), INDEX_SHIFT'(63)), 1'b0);

        // Random segments: mostly small working sets so lines are reused.
        total   = 0;
        drained = 1'b0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    kind = SEG_HAMMER;
                2:       kind = SEG_NOISE;
                default: kind = SEG_WORKING;
            endcase
            n_sets  = (kind == SEG_HAMMER) ? 1 : $urandom_range(1, 4);
            n_tags  = (kind == SEG_HAMMER) ? $urandom_range(9, 10) : $urandom_range(4, 12);
            seg_len = $urandom_range(30, 60);
            for (int s = 0; s < n_sets; s++) begin
                case ($urandom_range(0, 7))
                    0:       seg_sets[s] = '0;
                    1:       seg_sets[s] = '1;
                    default: seg_sets[s] = t_idx'($urandom);
                endcase
            end
            for (int t = 0; t < n_tags; t++) begin
                seg_tags[t] = ($urandom_range(0, 9) == 0) ? '1 : t_tag'($urandom);
            end
            for (int i = 0; i < seg_len; i++) begin
                if (kind == SEG_NOISE || $urandom_range(0, 19) == 0) addr = $urandom;
                else addr = make_addr(seg_tags[$urandom_range(0, n_tags - 1)],
                                      seg_sets[$urandom_range(0, n_sets - 1)],
                                      INDEX_SHIFT'($urandom));
                // Drain once after the directed part and once mid-run.
                add_req(addr, (total == 0) || (!drained && total >= RANDOM_ITEMS / 2));
                if (total >= RANDOM_ITEMS / 2) drained = 1'b1;
                total++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_q.size() != 0 || in_if.valid || results_open != 0);
        repeat (8) @(negedge i_clk);

        $display("Checked %0d lookups: %0d hits, %0d fills, %0d of them replacing a valid way.",
                 checked, hits_seen, fills, evictions);
        $display("Long receiver hold-off applied: %0d, mismatches: %0d.",
                 long_hold_done, errors);
        if (errors == 0 && lookups_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
